// File: src/lwkc_pkg.sv
// shared types and constants of the lru write-back key-value cache
package lwkc_pkg;

  localparam int CAPACITY_MAX_DEF = 16;
  localparam int KEY_BITS_DEF     = 32;
  localparam int VALUE_BITS_DEF   = 64;

  localparam int OPCODE_BITS   = 2;
  localparam int STATUS_BITS   = 2;
  localparam int CAPACITY_BITS = 5;

  localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 5'd16;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FLUSH  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_HIT       = 2'd1,
    STATUS_FILLED    = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic shift_en;
    logic shift_all;
    logic write_en;
    logic write_top;
  } update_ctl_t;

endpackage

// File: src/lwkc_if.sv
// request and response channel interfaces of the cache
interface lwkc_req_if #(
  parameter int KEY_BITS   = lwkc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lwkc_pkg::VALUE_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic [lwkc_pkg::OPCODE_BITS-1:0] opcode;
  logic [KEY_BITS-1:0]              key;
  logic [VALUE_BITS-1:0]            write_value;
  logic                             backing_found;
  logic [VALUE_BITS-1:0]            backing_value;

  modport source (output valid, opcode, key, write_value, backing_found, backing_value,
                  input ready);
  modport sink (input valid, opcode, key, write_value, backing_found, backing_value,
                output ready);
endinterface

interface lwkc_rsp_if #(
  parameter int KEY_BITS   = lwkc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lwkc_pkg::VALUE_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic [lwkc_pkg::STATUS_BITS-1:0] status;
  logic [VALUE_BITS-1:0]            read_value;
  logic                             evict_valid;
  logic [KEY_BITS-1:0]              evict_key;
  logic [VALUE_BITS-1:0]            evict_value;
  logic                             delete_request;
  logic                             last;

  modport source (output valid, status, read_value, evict_valid, evict_key, evict_value,
                  delete_request, last, input ready);
  modport sink (input valid, status, read_value, evict_valid, evict_key, evict_value,
                delete_request, last, output ready);
endinterface

// File: src/lwkc_entries.sv
// entry slots in recency order with parallel key match and shift update
module lwkc_entries #(
  parameter int DEPTH      = lwkc_pkg::CAPACITY_MAX_DEF,
  parameter int KEY_BITS   = lwkc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lwkc_pkg::VALUE_BITS_DEF,
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic [CNT_W-1:0]      count,
  input  logic [KEY_BITS-1:0]   lookup_key,
  input  logic [DEPTH-1:0]      shift_sel,
  input  logic [DEPTH-1:0]      write_sel,
  input  logic [KEY_BITS-1:0]   new_key,
  input  logic [VALUE_BITS-1:0] new_value,
  output logic                  hit,
  output logic [DEPTH-1:0]      match_ge,
  output logic [VALUE_BITS-1:0] hit_value,
  output logic [KEY_BITS-1:0]   head_key,
  output logic [VALUE_BITS-1:0] head_value
);

  logic [KEY_BITS-1:0]   keys   [DEPTH];
  logic [VALUE_BITS-1:0] values [DEPTH];
  logic [DEPTH-1:0]      match;
  logic [DEPTH-1:0]      match_first;

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    assign match[i] = (CNT_W'(i) < count) && (keys[i] == lookup_key);
    if (i < DEPTH - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (write_sel[i]) begin
          keys[i]   <= new_key;
          values[i] <= new_value;
        end else if (shift_sel[i]) begin
          keys[i]   <= keys[i+1];
          values[i] <= values[i+1];
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (write_sel[i]) begin
          keys[i]   <= new_key;
          values[i] <= new_value;
        end
      end
    end
  end

  // lowest match isolated, and every slot from it upward
  assign match_first = match & (~match + DEPTH'(1));
  assign match_ge    = match | (~match + DEPTH'(1));
  assign hit         = |match;
  assign head_key    = keys[0];
  assign head_value  = values[0];

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_value = hit_value | ({VALUE_BITS{match_first[i]}} & values[i]);
    end
  end

endmodule

// File: src/lru_writeback_kv_cache.sv
// top level of the lru write-back key-value cache
// usage:
//   requests enter on req (valid/ready) carrying opcode, key, write_value and the
//   backing store data; results leave on rsp (valid/ready), one per request, except
//   flush, which gives one result per cached entry or a single one when empty, least
//   recent first, with last set on the final one. evict_valid marks an entry to write back to backing store.
//   capacity is written through cfg_wen/cfg_wdata while the cache is empty and idle; the
//   block enforces only empty, idle is up to the user. writes while entries are held are
//   dropped. values above the slot count saturate. a request is registered in the request
//   stage at accept, and its result in the result stage once that is empty or taken.
//   throughput: one request per cycle while rsp is not held, set by the key match and
//   shift of the slot registers; a flush holds the request stage until its final entry goes.
//   reset: synchronous, clears entry count and both channel stages, capacity to 16.
//   stall: while rsp is held the result register keeps its value, the request
//   stage fills once and req.ready then drops until rsp is taken.
module lru_writeback_kv_cache #(
  parameter int CAPACITY_MAX = lwkc_pkg::CAPACITY_MAX_DEF,
  parameter int KEY_BITS     = lwkc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS   = lwkc_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  lwkc_req_if.sink                             req,
  lwkc_rsp_if.source                           rsp,
  input  logic                                 cfg_wen,
  input  logic [lwkc_pkg::CAPACITY_BITS-1:0]   cfg_wdata
);

  localparam int CNT_W = $clog2(CAPACITY_MAX + 1);
  localparam int CMP_W = (CNT_W > lwkc_pkg::CAPACITY_BITS) ? CNT_W : lwkc_pkg::CAPACITY_BITS;

  logic [lwkc_pkg::CAPACITY_BITS-1:0] capacity;
  logic [CNT_W-1:0]                   count;
  logic [CNT_W-1:0]                   count_next;
  logic [CNT_W-1:0]                   count_m1;
  logic [CNT_W-1:0]                   flush_pos;
  logic [CNT_W-1:0]                   flush_pos_next;
  logic [CMP_W-1:0]                   cap_eff;

  // request stage
  logic                  req_valid;
  lwkc_pkg::opcode_t     req_op;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_wval;
  logic                  req_bfound;
  logic [VALUE_BITS-1:0] req_bval;

  // result stage
  logic                  out_valid;
  lwkc_pkg::status_t     out_status;
  logic [VALUE_BITS-1:0] out_rval;
  logic                  out_ev;
  logic [KEY_BITS-1:0]   out_ek;
  logic [VALUE_BITS-1:0] out_evv;
  logic                  out_del;
  logic                  out_last;

  lwkc_pkg::status_t     status_next;
  logic [VALUE_BITS-1:0] rval_next;
  logic                  ev_next;
  logic [KEY_BITS-1:0]   ek_next;
  logic [VALUE_BITS-1:0] evv_next;
  logic                  del_next;
  logic                  last_next;

  logic                  advance;
  logic                  exec;
  logic                  consume;
  lwkc_pkg::update_ctl_t ctl;
  logic [CNT_W-1:0]      wpos;
  logic [KEY_BITS-1:0]   new_key;
  logic [VALUE_BITS-1:0] new_value;
  logic [CAPACITY_MAX-1:0] shift_sel;
  logic [CAPACITY_MAX-1:0] write_sel;

  logic                    hit;
  logic [CAPACITY_MAX-1:0] match_ge;
  logic [VALUE_BITS-1:0]   hit_value;
  logic [KEY_BITS-1:0]     head_key;
  logic [VALUE_BITS-1:0]   head_value;
  logic                    full;
  logic                    cap_zero;

  lwkc_entries #(
    .DEPTH      (CAPACITY_MAX),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .CNT_W      (CNT_W)
  ) u_entries (
    .clk        (clk),
    .count      (count),
    .lookup_key (req_key),
    .shift_sel  (shift_sel),
    .write_sel  (write_sel),
    .new_key    (new_key),
    .new_value  (new_value),
    .hit        (hit),
    .match_ge   (match_ge),
    .hit_value  (hit_value),
    .head_key   (head_key),
    .head_value (head_value)
  );

  assign cap_eff  = (CMP_W'(capacity) > CMP_W'(CAPACITY_MAX)) ? CMP_W'(CAPACITY_MAX)
                                                             : CMP_W'(capacity);
  assign full     = CMP_W'(count) >= cap_eff;
  assign cap_zero = cap_eff == '0;
  assign count_m1 = count - CNT_W'(1);

  assign advance   = !out_valid || rsp.ready;
  assign exec      = req_valid && advance;
  assign req.ready = !req_valid || (exec && consume);

  always_comb begin
    status_next    = lwkc_pkg::STATUS_DONE;
    rval_next      = '0;
    ev_next        = 1'b0;
    ek_next        = '0;
    evv_next       = '0;
    del_next       = 1'b0;
    last_next      = 1'b1;
    consume        = 1'b1;
    count_next     = count;
    flush_pos_next = flush_pos;
    ctl            = '0;
    new_key        = req_key;
    new_value      = req_wval;
    case (req_op)
      lwkc_pkg::OP_INSERT: begin
        if (hit) begin
          ctl.shift_en  = 1'b1;
          ctl.write_en  = 1'b1;
          ctl.write_top = 1'b1;
        end else if (cap_zero) begin
          ev_next  = 1'b1;
          ek_next  = req_key;
          evv_next = req_wval;
        end else if (full) begin
          ev_next       = 1'b1;
          ek_next       = head_key;
          evv_next      = head_value;
          ctl.shift_en  = 1'b1;
          ctl.shift_all = 1'b1;
          ctl.write_en  = 1'b1;
          ctl.write_top = 1'b1;
        end else begin
          ctl.write_en = 1'b1;
          count_next   = count + CNT_W'(1);
        end
      end
      lwkc_pkg::OP_LOOKUP: begin
        if (hit) begin
          status_next   = lwkc_pkg::STATUS_HIT;
          rval_next     = hit_value;
          new_value     = hit_value;
          ctl.shift_en  = 1'b1;
          ctl.write_en  = 1'b1;
          ctl.write_top = 1'b1;
        end else if (!req_bfound) begin
          status_next = lwkc_pkg::STATUS_NOT_FOUND;
        end else begin
          status_next = lwkc_pkg::STATUS_FILLED;
          rval_next   = req_bval;
          new_value   = req_bval;
          if (!cap_zero) begin
            if (full) begin
              ev_next       = 1'b1;
              ek_next       = head_key;
              evv_next      = head_value;
              ctl.shift_en  = 1'b1;
              ctl.shift_all = 1'b1;
              ctl.write_en  = 1'b1;
              ctl.write_top = 1'b1;
            end else begin
              ctl.write_en = 1'b1;
              count_next   = count + CNT_W'(1);
            end
          end
        end
      end
      lwkc_pkg::OP_REMOVE: begin
        del_next = 1'b1;
        if (hit) begin
          ctl.shift_en = 1'b1;
          count_next   = count_m1;
        end
      end
      lwkc_pkg::OP_FLUSH: begin
        if (count != '0) begin
          // rotate the head to the top so the order is back after count steps
          ev_next       = 1'b1;
          ek_next       = head_key;
          evv_next      = head_value;
          new_key       = head_key;
          new_value     = head_value;
          ctl.shift_en  = 1'b1;
          ctl.shift_all = 1'b1;
          ctl.write_en  = 1'b1;
          ctl.write_top = 1'b1;
          last_next     = flush_pos == count_m1;
          consume       = last_next;
          flush_pos_next = last_next ? '0 : flush_pos + CNT_W'(1);
        end
      end
      default: begin
        status_next = lwkc_pkg::STATUS_DONE;
      end
    endcase
  end

  assign wpos = ctl.write_top ? count_m1 : count;

  always_comb begin
    for (int i = 0; i < CAPACITY_MAX; i++) begin
      shift_sel[i] = exec && ctl.shift_en && (ctl.shift_all || match_ge[i])
                     && (CNT_W'(i) < count_m1);
      write_sel[i] = exec && ctl.write_en && (CNT_W'(i) == wpos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= lwkc_pkg::CAPACITY_RESET;
      count     <= '0;
      flush_pos <= '0;
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wen && count == '0) begin
        capacity <= cfg_wdata;
      end
      if (exec) begin
        count     <= count_next;
        flush_pos <= flush_pos_next;
      end
      if (req.ready) begin
        req_valid <= req.valid;
      end
      if (exec) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_op     <= lwkc_pkg::opcode_t'(req.opcode);
      req_key    <= req.key;
      req_wval   <= req.write_value;
      req_bfound <= req.backing_found;
      req_bval   <= req.backing_value;
    end
    if (exec) begin
      out_status <= status_next;
      out_rval   <= rval_next;
      out_ev     <= ev_next;
      out_ek     <= ek_next;
      out_evv    <= evv_next;
      out_del    <= del_next;
      out_last   <= last_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.read_value     = out_rval;
  assign rsp.evict_valid    = out_ev;
  assign rsp.evict_key      = out_ek;
  assign rsp.evict_value    = out_evv;
  assign rsp.delete_request = out_del;
  assign rsp.last           = out_last;

endmodule

// File: src/lwkc_checker.sv
// port-level checks of the cache, bound to the top level
module lwkc_checker #(
  parameter int KEY_BITS   = lwkc_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lwkc_pkg::VALUE_BITS_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic [lwkc_pkg::STATUS_BITS-1:0] rsp_status,
  input logic [VALUE_BITS-1:0]            rsp_read_value,
  input logic                             rsp_evict_valid,
  input logic [KEY_BITS-1:0]              rsp_evict_key,
  input logic [VALUE_BITS-1:0]            rsp_evict_value,
  input logic                             rsp_delete_request,
  input logic                             rsp_last
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_evict_key)
                                && $stable(rsp_last) && $stable(rsp_status))
    else $error("stalled result changed");

  // no write-back data without evict_valid
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_evict_valid |-> rsp_evict_key == '0 && rsp_evict_value == '0)
    else $error("write-back fields set without evict_valid");

  // delete request is a single done result with no write-back
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_delete_request |-> rsp_status == lwkc_pkg::STATUS_DONE
                                        && !rsp_evict_valid && rsp_last)
    else $error("delete request with wrong companions");

  // read value only with hit or fill
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == lwkc_pkg::STATUS_DONE
                  || rsp_status == lwkc_pkg::STATUS_NOT_FOUND) |-> rsp_read_value == '0)
    else $error("read value without hit or fill");

  // non-final results only come from flush write-backs
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> rsp_evict_valid && rsp_status == lwkc_pkg::STATUS_DONE)
    else $error("non-final result outside a flush");

endmodule

bind lru_writeback_kv_cache lwkc_checker #(
  .KEY_BITS   (KEY_BITS),
  .VALUE_BITS (VALUE_BITS)
) u_lwkc_checker (
  .clk                (clk),
  .rst                (rst),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_read_value     (rsp.read_value),
  .rsp_evict_valid    (rsp.evict_valid),
  .rsp_evict_key      (rsp.evict_key),
  .rsp_evict_value    (rsp.evict_value),
  .rsp_delete_request (rsp.delete_request),
  .rsp_last           (rsp.last)
);

// File: tb/sv/lru_writeback_kv_cache_tb.sv
// self-checking testbench of the lru write-back key-value cache: directed, random and stall tests
module lru_writeback_kv_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS          = lwkc_pkg::CAPACITY_MAX_DEF;
  localparam int KW             = lwkc_pkg::KEY_BITS_DEF;
  localparam int VW             = lwkc_pkg::VALUE_BITS_DEF;
  localparam int CW             = lwkc_pkg::CAPACITY_BITS;
  localparam int POOL_SIZE      = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int PHASE_ITEMS    = 38;

  typedef struct {
    lwkc_pkg::status_t status;
    logic [VW-1:0]     read_value;
    logic              evict_valid;
    logic [KW-1:0]     evict_key;
    logic [VW-1:0]     evict_value;
    logic              delete_request;
    logic              last;
  } cache_result_t;

  logic          clk = 1'b0;
  logic          rst;
  logic          cfg_wen;
  logic [CW-1:0] cfg_wdata;

  lwkc_req_if req_if ();
  lwkc_rsp_if rsp_if ();

  lru_writeback_kv_cache u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow copy of the cache contents, slot 0 least recent
  logic [KW-1:0]  slot_key [SLOTS];
  logic [VW-1:0]  slot_value [SLOTS];
  int unsigned    slot_count = 0;
  logic [CW-1:0]  capacity_reg = lwkc_pkg::CAPACITY_RESET;

  // expected results in order, indexed by running position
  cache_result_t  expected_results [int];
  int             exp_head = 0;
  int             exp_tail = 0;

  logic [KW-1:0] key_pool [POOL_SIZE];
  int fail_count      = 0;
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int hold_requests   = 0;
  int hold_served     = 0;
  int idle_cycles     = 0;

  function automatic void add_expected(cache_result_t r);
    expected_results[exp_tail] = r;
    exp_tail++;
  endfunction

  function automatic cache_result_t take_expected();
    cache_result_t r;
    r = expected_results[exp_head];
    expected_results.delete(exp_head);
    exp_head++;
    return r;
  endfunction

  function automatic int pending_results();
    return exp_tail - exp_head;
  endfunction

  function automatic int find_slot(logic [KW-1:0] key);
    for (int i = 0; i < slot_count; i++) begin
      if (slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(int idx);
    for (int i = idx; i + 1 < slot_count; i++) begin
      slot_key[i]   = slot_key[i+1];
      slot_value[i] = slot_value[i+1];
    end
    slot_count--;
  endfunction

  function automatic void append_slot(logic [KW-1:0] key, logic [VW-1:0] value);
    if (slot_count < SLOTS) begin
      slot_key[slot_count]   = key;
      slot_value[slot_count] = value;
      slot_count++;
    end
  endfunction

  function automatic void evict_oldest(inout cache_result_t r);
    r.evict_valid = 1'b1;
    r.evict_key   = slot_key[0];
    r.evict_value = slot_value[0];
    drop_slot(0);
  endfunction

  function automatic void predict_request(lwkc_pkg::opcode_t op, logic [KW-1:0] key,
                                          logic [VW-1:0] wvalue, logic bfound,
                                          logic [VW-1:0] bvalue);
    int            slot;
    int unsigned   cap;
    cache_result_t r;
    logic [VW-1:0] hit_value;
    cap              = (capacity_reg > SLOTS) ? SLOTS : capacity_reg;
    slot             = find_slot(key);
    r.status         = lwkc_pkg::STATUS_DONE;
    r.read_value     = '0;
    r.evict_valid    = 1'b0;
    r.evict_key      = '0;
    r.evict_value    = '0;
    r.delete_request = 1'b0;
    r.last           = 1'b1;
    case (op)
      lwkc_pkg::OP_INSERT: begin
        if (slot >= 0) begin
          drop_slot(slot);
          append_slot(key, wvalue);
        end else if (cap == 0) begin
          r.evict_valid = 1'b1;
          r.evict_key   = key;
          r.evict_value = wvalue;
        end else begin
          if (slot_count >= cap) evict_oldest(r);
          append_slot(key, wvalue);
        end
        add_expected(r);
      end
      lwkc_pkg::OP_LOOKUP: begin
        if (slot >= 0) begin
          hit_value = slot_value[slot];
          drop_slot(slot);
          append_slot(key, hit_value);
          r.status     = lwkc_pkg::STATUS_HIT;
          r.read_value = hit_value;
        end else if (!bfound) begin
          r.status = lwkc_pkg::STATUS_NOT_FOUND;
        end else begin
          r.status     = lwkc_pkg::STATUS_FILLED;
          r.read_value = bvalue;
          if (cap != 0) begin
            if (slot_count >= cap) evict_oldest(r);
            append_slot(key, bvalue);
          end
        end
        add_expected(r);
      end
      lwkc_pkg::OP_REMOVE: begin
        if (slot >= 0) drop_slot(slot);
        r.delete_request = 1'b1;
        add_expected(r);
      end
      default: begin
        if (slot_count == 0) begin
          add_expected(r);
        end else begin
          for (int i = 0; i < slot_count; i++) begin
            r.evict_valid = 1'b1;
            r.evict_key   = slot_key[i];
            r.evict_value = slot_value[i];
            r.last        = (i + 1 == slot_count);
            add_expected(r);
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [VW-1:0] expected,
                                      logic [VW-1:0] actual);
    if (actual !== expected) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    cache_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results() == 0) begin
        $error("result with no request pending: status %0d evict_key 0x%0h",
               rsp_if.status, rsp_if.evict_key);
        fail_count++;
      end else begin
        want = take_expected();
        check_field("status", want.status, rsp_if.status);
        check_field("read_value", want.read_value, rsp_if.read_value);
        check_field("evict_valid", want.evict_valid, rsp_if.evict_valid);
        check_field("evict_key", want.evict_key, rsp_if.evict_key);
        check_field("evict_value", want.evict_value, rsp_if.evict_value);
        check_field("delete_request", want.delete_request, rsp_if.delete_request);
        check_field("last", want.last, rsp_if.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result receiver: random stalls, plus a long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served < hold_requests) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served++;
      end
      rsp_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [VW-1:0] random_value();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KW-1:0] random_key();
    if ($urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(POOL_SIZE-1)];
  endfunction

  task automatic refill_key_pool();
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
  endtask

  // starts at a falling edge, returns at the accepting rising edge
  task automatic send_request(lwkc_pkg::opcode_t op, logic [KW-1:0] key,
                              logic [VW-1:0] wvalue, logic bfound, logic [VW-1:0] bvalue);
    @(negedge clk);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.opcode        <= op;
    req_if.key           <= key;
    req_if.write_value   <= wvalue;
    req_if.backing_found <= bfound;
    req_if.backing_value <= bvalue;
    do @(posedge clk); while (!req_if.ready);
    predict_request(op, key, wvalue, bfound, bvalue);
  endtask

  task automatic send_random_request();
    int                pick;
    lwkc_pkg::opcode_t op;
    pick = $urandom_range(99);
    if (pick < 38) op = lwkc_pkg::OP_INSERT;
    else if (pick < 74) op = lwkc_pkg::OP_LOOKUP;
    else if (pick < 90) op = lwkc_pkg::OP_REMOVE;
    else op = lwkc_pkg::OP_FLUSH;
    send_request(op, random_key(), random_value(), 1'($urandom_range(1)), random_value());
  endtask

  task automatic release_request();
    @(negedge clk);
    req_if.valid <= 1'b0;
  endtask

  task automatic drain_cache();
    while (slot_count != 0) begin
      send_request(lwkc_pkg::OP_REMOVE, slot_key[0], random_value(), 1'b0, '0);
    end
  endtask

  task automatic write_capacity(logic [CW-1:0] value);
    release_request();
    while (pending_results() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    if (slot_count == 0) capacity_reg = value;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic test_directed();
    sender_idle_pct = 0;
    stall_pct       = 0;
    send_request(lwkc_pkg::OP_INSERT, 32'h0000_0000, 64'h0, 1'b0, 64'h0);
    send_request(lwkc_pkg::OP_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0);
    send_request(lwkc_pkg::OP_LOOKUP, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h1);
    send_request(lwkc_pkg::OP_LOOKUP, 32'hA5A5_A5A5, 64'h0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(lwkc_pkg::OP_LOOKUP, 32'h5A5A_5A5A, 64'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(lwkc_pkg::OP_INSERT, 32'h0000_0000, 64'h0123_4567_89AB_CDEF, 1'b0, 64'h0);
    send_request(lwkc_pkg::OP_FLUSH, 32'h0, 64'h0, 1'b0, 64'h0);
    send_request(lwkc_pkg::OP_REMOVE, 32'hFFFF_FFFF, 64'h0, 1'b0, 64'h0);
    send_request(lwkc_pkg::OP_REMOVE, 32'h1234_5678, 64'h0, 1'b0, 64'h0);
    // capacity write is dropped while entries are held
    write_capacity(5'd1);
    send_request(lwkc_pkg::OP_INSERT, 32'h0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0, 64'h0);
    send_request(lwkc_pkg::OP_FLUSH, 32'h0, 64'h0, 1'b0, 64'h0);
    drain_cache();
    send_request(lwkc_pkg::OP_FLUSH, 32'h0, 64'h0, 1'b0, 64'h0);
    // caching disabled
    write_capacity(5'd0);
    send_request(lwkc_pkg::OP_INSERT, 32'hDEAD_BEEF, 64'hCAFE_F00D_0000_0001, 1'b0, 64'h0);
    send_request(lwkc_pkg::OP_LOOKUP, 32'hDEAD_BEEF, 64'h0, 1'b1, 64'h8000_0000_0000_0001);
    send_request(lwkc_pkg::OP_LOOKUP, 32'hDEAD_BEEF, 64'h0, 1'b0, 64'h7);
    write_capacity(5'd2);
    send_request(lwkc_pkg::OP_INSERT, 32'h0000_0001, 64'h11, 1'b0, 64'h0);
    send_request(lwkc_pkg::OP_INSERT, 32'h0000_0002, 64'h22, 1'b0, 64'h0);
    send_request(lwkc_pkg::OP_INSERT, 32'h0000_0003, 64'h33, 1'b0, 64'h0);
    send_request(lwkc_pkg::OP_LOOKUP, 32'h0000_0004, 64'h0, 1'b1, 64'h44);
    drain_cache();
  endtask

  task automatic run_phase(logic [CW-1:0] cap, int sender_pct, int receiver_pct,
                           int count);
    drain_cache();
    write_capacity(cap);
    sender_idle_pct = sender_pct;
    stall_pct       = receiver_pct;
    refill_key_pool();
    repeat (count) send_random_request();
  endtask

  task automatic test_random_phases();
    run_phase(5'd16, 0, 0, PHASE_ITEMS);
    run_phase(5'd3, 67, 0, PHASE_ITEMS);
    run_phase(5'd0, 0, 67, PHASE_ITEMS);
    run_phase(5'd31, 34, 34, PHASE_ITEMS);
    run_phase(5'd1, 0, 0, PHASE_ITEMS);
    run_phase(5'd8, 67, 0, PHASE_ITEMS);
    run_phase(5'd16, 0, 67, PHASE_ITEMS);
    run_phase(5'd5, 34, 34, PHASE_ITEMS);
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    drain_cache();
    write_capacity(5'd4);
    sender_idle_pct = 0;
    stall_pct       = 0;
    refill_key_pool();
    hold_requests++;
    repeat (40) send_random_request();
  endtask

  initial begin
    rst                  = 1'b1;
    cfg_wen              = 1'b0;
    cfg_wdata            = '0;
    req_if.valid         = 1'b0;
    req_if.opcode        = lwkc_pkg::OP_INSERT;
    req_if.key           = '0;
    req_if.write_value   = '0;
    req_if.backing_found = 1'b0;
    req_if.backing_value = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phases();
    test_backpressure();
    release_request();
    while (pending_results() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_results() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
src/lwkc_pkg.sv
src/lwkc_if.sv
src/lwkc_entries.sv
src/lru_writeback_kv_cache.sv
src/lwkc_checker.sv
tb/sv/lru_writeback_kv_cache_tb.sv
